FILE: src/rld_pkg.sv
// Shared types, constants and helper functions for the rational lens distortion block.
`default_nettype none

package rld_pkg;

  // Field widths of the streaming words and the configuration port.
  localparam int POS_W      = 20;
  localparam int TEX_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int NREGS      = 8;
  localparam int CFG_IDX_W  = $clog2(NREGS);

  // Internal fixed point: signed Q.28 held in 64 bits.
  localparam int DW     = 64;
  localparam int FRAC_W = 28;

  // Normalization by the half-size uses a reciprocal of 2^RCP_SHIFT / half.
  localparam int NORM_W    = 21;
  localparam int RCP_SHIFT = 52;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam int RCP_SPLIT = 27;
  localparam int NSUM_W    = 75;
  localparam int NQ_SHIFT  = 32;
  localparam int NQ_W      = NSUM_W - NQ_SHIFT;

  // Conversion back to pixels keeps a Q.8 value of this width before the clamp.
  localparam int PIX_SHIFT = 20;
  localparam int Q8_W      = 44;

  // Pipeline depths of the arithmetic units.
  localparam int MUL_LAT  = 4;
  localparam int QUO_BITS = 62;
  localparam int DIV_LAT  = QUO_BITS + 2;

  localparam int HALF_WIDTH_DEF  = 160;
  localparam int HALF_HEIGHT_DEF = 120;

  typedef logic signed [DW-1:0]         q28_t;
  typedef logic signed [CFG_DATA_W-1:0] coef_t;

  localparam q28_t LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam q28_t ONE_Q28 = 64'sh0000_0000_1000_0000;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1,
    REG_K2,
    REG_K3,
    REG_K4,
    REG_K5,
    REG_K6,
    REG_P1,
    REG_P2
  } cfg_reg_t;

  localparam coef_t COEF_RESET [NREGS] = '{
    32'sd57809424, -32'sd31533877, -32'sd1217777, 32'sd153837843,
    -32'sd34245540, -32'sd7680625, -32'sd82194, -32'sd29379
  };

  // Saturating add; both operands are always within the saturation limit.
  function automatic q28_t sadd(q28_t a, q28_t b);
    q28_t s;
    q28_t r;
    s = a + b;
    if (s > LIM) begin
      r = LIM;
    end else if (s < -LIM) begin
      r = -LIM;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Sign-extend a coefficient to the internal format.
  function automatic q28_t coef_ext(coef_t c);
    return q28_t'(c);
  endfunction

endpackage

`default_nettype wire

FILE: src/rld_if.sv
// Streaming channel interfaces for vertex words in and distorted words out.
`default_nettype none

interface rld_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rld_pkg::POS_W-1:0]  pos_x;
  logic signed [rld_pkg::POS_W-1:0]  pos_y;
  logic        [rld_pkg::TEX_W-1:0]  tex_u;
  logic        [rld_pkg::TEX_W-1:0]  tex_v;

  modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                output ready);
endinterface

interface rld_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rld_pkg::POS_W-1:0]  dist_x;
  logic signed [rld_pkg::POS_W-1:0]  dist_y;
  logic        [rld_pkg::TEX_W-1:0]  tex_u_out;
  logic        [rld_pkg::TEX_W-1:0]  tex_v_out;
  logic                              bad_denominator;

  modport source (output valid, output dist_x, output dist_y, output tex_u_out,
                  output tex_v_out, output bad_denominator, input ready);
  modport sink (input valid, input dist_x, input dist_y, input tex_u_out,
                input tex_v_out, input bad_denominator, output ready);
endinterface

`default_nettype wire

FILE: src/rld_mulq.sv
// Pipelined Q.28 multiplier with truncation toward zero and saturation.
`default_nettype none

module rld_mulq (
  input  logic          clk,
  input  logic          en,
  input  rld_pkg::q28_t a,
  input  rld_pkg::q28_t b,
  output rld_pkg::q28_t p
);

  logic [63:0]   ua_r, ub_r;
  logic          neg1_r;
  logic [63:0]   p00_r, p01_r, p10_r, p11_r;
  logic          neg2_r;
  logic [63:0]   hi_r, lo_r;
  logic          neg3_r;
  rld_pkg::q28_t p_r;

  logic [63:0]   mid_nxt, hi_nxt, lo_nxt;
  logic [61:0]   mag_nxt;
  rld_pkg::q28_t p_nxt;

  // Carry the 128-bit magnitude product into high and low words.
  always_comb begin
    mid_nxt = {32'b0, p00_r[63:32]} + {32'b0, p01_r[31:0]} + {32'b0, p10_r[31:0]};
    hi_nxt  = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]} + {32'b0, mid_nxt[63:32]};
    lo_nxt  = {mid_nxt[31:0], p00_r[31:0]};
  end

  // Drop 28 fraction bits, saturate, and put the sign back.
  always_comb begin
    if (|hi_r[63:26]) begin
      mag_nxt = {62{1'b1}};
    end else begin
      mag_nxt = {hi_r[25:0], lo_r[63:28]};
    end
    p_nxt = neg3_r ? -rld_pkg::q28_t'({2'b0, mag_nxt}) : rld_pkg::q28_t'({2'b0, mag_nxt});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitudes and result sign.
      ua_r   <= (a < 0) ? 64'(-a) : 64'(a);
      ub_r   <= (b < 0) ? 64'(-b) : 64'(b);
      neg1_r <= (a < 0) != (b < 0);
      // Four 32 by 32 partial products.
      p00_r  <= 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
      p01_r  <= 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
      p10_r  <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      p11_r  <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      neg2_r <= neg1_r;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      neg3_r <= neg2_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

FILE: src/rld_div.sv
// Pipelined Q.28 divider, one quotient bit per stage, for a positive divisor.
`default_nettype none

module rld_div (
  input  logic          clk,
  input  logic          en,
  input  rld_pkg::q28_t num,
  input  rld_pkg::q28_t den,
  output rld_pkg::q28_t quo
);

  localparam int QB = rld_pkg::QUO_BITS;
  localparam int FW = rld_pkg::FRAC_W;
  localparam int IB = QB - FW;

  logic [QB:0]   rem_r  [QB+1];
  logic [QB-1:0] dvs_r  [QB+1];
  logic [QB-1:0] bits_r [QB+1];
  logic [QB-1:0] quo_r  [QB+1];
  logic          ovf_r  [QB+1];
  logic          neg_r  [QB+1];
  rld_pkg::q28_t quo_out_r;

  logic [63:0]      un_nxt;
  logic [QB-1:0]    un62_nxt;
  logic             ovf_nxt;
  rld_pkg::q28_t    res_nxt;

  // Magnitude of the dividend and the check for an integer part of 2^34 or more.
  always_comb begin
    un_nxt   = (num < 0) ? 64'(-num) : 64'(num);
    un62_nxt = un_nxt[QB-1:0];
    ovf_nxt  = {{IB{1'b0}}, un62_nxt} >= {den[QB-1:0], {IB{1'b0}}};
  end

  // Final sign and saturation.
  always_comb begin
    if (ovf_r[QB]) begin
      res_nxt = neg_r[QB] ? -rld_pkg::LIM : rld_pkg::LIM;
    end else begin
      res_nxt = neg_r[QB] ? -rld_pkg::q28_t'({2'b0, quo_r[QB]})
                          : rld_pkg::q28_t'({2'b0, quo_r[QB]});
    end
  end

  always_ff @(posedge clk) begin
    logic [QB:0] sh;
    if (en) begin
      // Setup: the first remainder holds the top dividend bits.
      rem_r[0]  <= (QB+1)'(un62_nxt[QB-1:IB]);
      dvs_r[0]  <= den[QB-1:0];
      bits_r[0] <= {un62_nxt[IB-1:0], {FW{1'b0}}};
      quo_r[0]  <= '0;
      ovf_r[0]  <= ovf_nxt;
      neg_r[0]  <= num < 0;
      // Restoring steps: shift in one dividend bit, subtract when it fits.
      for (int k = 0; k < QB; k++) begin
        sh = {rem_r[k][QB-1:0], bits_r[k][QB-1]};
        if (sh >= {1'b0, dvs_r[k]}) begin
          rem_r[k+1] <= sh - {1'b0, dvs_r[k]};
          quo_r[k+1] <= {quo_r[k][QB-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= sh;
          quo_r[k+1] <= {quo_r[k][QB-2:0], 1'b0};
        end
        dvs_r[k+1]  <= dvs_r[k];
        bits_r[k+1] <= {bits_r[k][QB-2:0], 1'b0};
        ovf_r[k+1]  <= ovf_r[k];
        neg_r[k+1]  <= neg_r[k];
      end
      quo_out_r <= res_nxt;
    end
  end

  assign quo = quo_out_r;

endmodule

`default_nettype wire

FILE: src/rational_lens_distortion_point.sv
// Top level of the rational radial and tangential lens distortion pipeline.
// Each vertex word (Q12.8 position plus texture coordinate) is normalized about the
// half-size, run through the rational radial model and the tangential terms, and mapped
// back to pixels with saturation. The block takes one word per clock unless a finished
// word waits untaken at the output; its depth is set mostly by the 62-stage quotient
// pipeline for N/D, one quotient bit per stage, plus 4-stage multipliers. A denominator
// at or below zero flags bad_denominator and returns the input position. When the
// output word is not taken, the whole pipeline holds. Coefficients may be written only
// while no word is in flight.
`default_nettype none

module rational_lens_distortion_point #(
  parameter int HALF_WIDTH  = rld_pkg::HALF_WIDTH_DEF,
  parameter int HALF_HEIGHT = rld_pkg::HALF_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rld_pkg::CFG_DATA_W-1:0]  cfg_data,
  rld_in_if.sink                          in_ch,
  rld_out_if.source                       out_ch
);

  localparam int L  = rld_pkg::MUL_LAT;
  localparam int NW = rld_pkg::NORM_W;
  localparam int RW = rld_pkg::RCP_W;
  localparam int RS = rld_pkg::RCP_SPLIT;
  localparam int SW = rld_pkg::NSUM_W;
  localparam int QW = rld_pkg::NQ_W;
  localparam int PW = rld_pkg::POS_W;
  localparam int Q8 = rld_pkg::Q8_W;

  // Stage positions along the pipeline.
  localparam int T_XN  = 2;
  localparam int T_SQ  = T_XN + L;
  localparam int T_R2  = T_SQ + 1;
  localparam int T_SX  = T_R2 + 1;
  localparam int T_TM  = T_SX + L;
  localparam int T_TS  = T_TM + 1;
  localparam int T_R4  = T_R2 + L;
  localparam int T_N1  = T_R4 + 1;
  localparam int T_R6  = T_R4 + L;
  localparam int T_N2  = T_R6 + 1;
  localparam int T_R6M = T_R6 + L;
  localparam int T_ND  = T_R6M + 1;
  localparam int T_Q   = T_ND + rld_pkg::DIV_LAT;
  localparam int T_RX  = T_Q + L;
  localparam int T_DX  = T_RX + 1;
  localparam int T_PX  = T_DX + L;
  localparam int T_SH  = T_PX + 1;
  localparam int T_OUT = T_SH + 1;

  // Delay line lengths.
  localparam int D_IN  = T_SH;
  localparam int D_XN  = T_Q - T_XN;
  localparam int D_TG  = T_RX - T_TS;
  localparam int D_R2  = T_R4 - T_R2;
  localparam int D_N1  = T_R6 - T_N1;
  localparam int D_N2  = T_R6M - T_N2;
  localparam int D_BAD = T_SH - T_ND;

  // Per-axis constants: center offset, reciprocal of the half-size, pixel scale.
  localparam logic signed [NW-1:0] OFF [2] = '{NW'(HALF_WIDTH * 256), NW'(HALF_HEIGHT * 256)};
  localparam logic signed [Q8-1:0] OFF8 [2] = '{Q8'(HALF_WIDTH * 256), Q8'(HALF_HEIGHT * 256)};
  localparam logic [RW-1:0] RCP [2] = '{
    RW'(((64'd1 << rld_pkg::RCP_SHIFT) + 64'(HALF_WIDTH) - 64'd1) / 64'(HALF_WIDTH)),
    RW'(((64'd1 << rld_pkg::RCP_SHIFT) + 64'(HALF_HEIGHT) - 64'd1) / 64'(HALF_HEIGHT))
  };
  localparam rld_pkg::q28_t SCALE [2] = '{
    rld_pkg::q28_t'(64'(HALF_WIDTH) << rld_pkg::FRAC_W),
    rld_pkg::q28_t'(64'(HALF_HEIGHT) << rld_pkg::FRAC_W)
  };

  typedef struct packed {
    logic signed [PW-1:0]            pos_x;
    logic signed [PW-1:0]            pos_y;
    logic [rld_pkg::TEX_W-1:0]       tex_u;
    logic [rld_pkg::TEX_W-1:0]       tex_v;
  } word_t;

  typedef struct packed {
    rld_pkg::q28_t x;
    rld_pkg::q28_t y;
  } pair_t;

  logic adv;
  logic [T_OUT:0] vld_r;

  rld_pkg::coef_t coef_r [rld_pkg::NREGS];
  rld_pkg::q28_t  k1, k2, k3, k4, k5, k6, p1, p2;

  word_t          in_r;
  word_t          in_d_r [D_IN];
  logic [47:0]    nl_r [2];
  logic [46:0]    nh_r [2];
  logic           nneg_r [2];
  pair_t          xn_r;
  pair_t          xn_d_r [D_XN];
  rld_pkg::q28_t  xx, yy, xyp;
  rld_pkg::q28_t  r2_r, xy2_r, tx_r, ty_r;
  rld_pkg::q28_t  r2_d_r [D_R2];
  rld_pkg::q28_t  sx_r, sy_r, xy2_d_r;
  rld_pkg::q28_t  ta, tb, tc, td;
  pair_t          tg_r;
  pair_t          tg_d_r [D_TG];
  rld_pkg::q28_t  r4, k1r2, k4r2;
  pair_t          nd1_r;
  pair_t          nd1_d_r [D_N1];
  rld_pkg::q28_t  r6, k2r4, k5r4;
  pair_t          nd2_r;
  pair_t          nd2_d_r [D_N2];
  rld_pkg::q28_t  k3r6, k6r6;
  rld_pkg::q28_t  num_r, den_r;
  logic           bad_d_r [D_BAD];
  rld_pkg::q28_t  ratio;
  rld_pkg::q28_t  rx, ry;
  pair_t          dx_r;
  rld_pkg::q28_t  vx, vy;
  logic signed [Q8-1:0] q8_r [2];

  logic signed [PW-1:0]      dist_x_r, dist_y_r;
  logic [rld_pkg::TEX_W-1:0] tex_u_r, tex_v_r;
  logic                      bad_r;

  logic signed [NW-1:0] nval_nxt [2];
  logic [NW-1:0]        nmag_nxt [2];
  logic [SW-1:0]        nsum_nxt [2];
  logic [QW-1:0]        nq_nxt [2];
  pair_t                xn_nxt;
  logic [63:0]          vmag_nxt [2];
  logic signed [Q8-1:0] q8_nxt [2];
  logic signed [Q8-1:0] pix_nxt [2];
  logic signed [PW-1:0] clamp_nxt [2];

  // The pipeline moves unless a finished word waits at the output.
  assign adv         = !vld_r[T_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[T_OUT-1:0], in_ch.valid};
    end
  end

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= rld_pkg::COEF_RESET;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= rld_pkg::coef_t'(cfg_data);
    end
  end

  assign k1 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K1]);
  assign k2 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K2]);
  assign k3 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K3]);
  assign k4 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K4]);
  assign k5 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K5]);
  assign k6 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_K6]);
  assign p1 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_P1]);
  assign p2 = rld_pkg::coef_ext(coef_r[rld_pkg::REG_P2]);

  // Normalization: (pos - half*256) * 2^20 / half through a reciprocal multiply.
  always_comb begin
    nval_nxt[0] = NW'(in_r.pos_x) - OFF[0];
    nval_nxt[1] = NW'(in_r.pos_y) - OFF[1];
    for (int a = 0; a < 2; a++) begin
      nmag_nxt[a] = (nval_nxt[a] < 0) ? NW'(-nval_nxt[a]) : NW'(nval_nxt[a]);
      nsum_nxt[a] = SW'(nl_r[a]) + (SW'(nh_r[a]) << RS);
      nq_nxt[a]   = nsum_nxt[a][SW-1:rld_pkg::NQ_SHIFT];
    end
    xn_nxt.x = nneg_r[0] ? -rld_pkg::q28_t'(nq_nxt[0]) : rld_pkg::q28_t'(nq_nxt[0]);
    xn_nxt.y = nneg_r[1] ? -rld_pkg::q28_t'(nq_nxt[1]) : rld_pkg::q28_t'(nq_nxt[1]);
  end

  // Input capture, normalization stages and the passthrough delay line.
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= '{pos_x: in_ch.pos_x, pos_y: in_ch.pos_y, tex_u: in_ch.tex_u,
                tex_v: in_ch.tex_v};
      for (int a = 0; a < 2; a++) begin
        nl_r[a]   <= 48'(nmag_nxt[a]) * 48'(RCP[a][RS-1:0]);
        nh_r[a]   <= 47'(nmag_nxt[a]) * 47'(RCP[a][RW-1:RS]);
        nneg_r[a] <= nval_nxt[a] < 0;
      end
      xn_r <= xn_nxt;
      in_d_r[0] <= in_r;
      for (int i = 1; i < D_IN; i++) in_d_r[i] <= in_d_r[i-1];
      xn_d_r[0] <= xn_r;
      for (int i = 1; i < D_XN; i++) xn_d_r[i] <= xn_d_r[i-1];
    end
  end

  // Squares and the cross product of the normalized point.
  rld_mulq u_mul_xx (.clk(clk), .en(adv), .a(xn_r.x), .b(xn_r.x), .p(xx));
  rld_mulq u_mul_yy (.clk(clk), .en(adv), .a(xn_r.y), .b(xn_r.y), .p(yy));
  rld_mulq u_mul_xy (.clk(clk), .en(adv), .a(xn_r.x), .b(xn_r.y), .p(xyp));

  // Radius squared, doubled cross term and the tangential sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r    <= rld_pkg::sadd(xx, yy);
      xy2_r   <= rld_pkg::sadd(xyp, xyp);
      tx_r    <= rld_pkg::sadd(xx, xx);
      ty_r    <= rld_pkg::sadd(yy, yy);
      sx_r    <= rld_pkg::sadd(r2_r, tx_r);
      sy_r    <= rld_pkg::sadd(r2_r, ty_r);
      xy2_d_r <= xy2_r;
      r2_d_r[0] <= r2_r;
      for (int i = 1; i < D_R2; i++) r2_d_r[i] <= r2_d_r[i-1];
    end
  end

  // Tangential products.
  rld_mulq u_mul_ta (.clk(clk), .en(adv), .a(p1), .b(xy2_d_r), .p(ta));
  rld_mulq u_mul_tb (.clk(clk), .en(adv), .a(p2), .b(sx_r),    .p(tb));
  rld_mulq u_mul_tc (.clk(clk), .en(adv), .a(p1), .b(sy_r),    .p(tc));
  rld_mulq u_mul_td (.clk(clk), .en(adv), .a(p2), .b(xy2_d_r), .p(td));

  always_ff @(posedge clk) begin
    if (adv) begin
      tg_r.x <= rld_pkg::sadd(ta, tb);
      tg_r.y <= rld_pkg::sadd(tc, td);
      tg_d_r[0] <= tg_r;
      for (int i = 1; i < D_TG; i++) tg_d_r[i] <= tg_d_r[i-1];
    end
  end

  // First powers of r squared against the coefficients.
  rld_mulq u_mul_r4   (.clk(clk), .en(adv), .a(r2_r), .b(r2_r), .p(r4));
  rld_mulq u_mul_k1r2 (.clk(clk), .en(adv), .a(k1),   .b(r2_r), .p(k1r2));
  rld_mulq u_mul_k4r2 (.clk(clk), .en(adv), .a(k4),   .b(r2_r), .p(k4r2));

  rld_mulq u_mul_r6   (.clk(clk), .en(adv), .a(r4), .b(r2_d_r[D_R2-1]), .p(r6));
  rld_mulq u_mul_k2r4 (.clk(clk), .en(adv), .a(k2), .b(r4), .p(k2r4));
  rld_mulq u_mul_k5r4 (.clk(clk), .en(adv), .a(k5), .b(r4), .p(k5r4));

  rld_mulq u_mul_k3r6 (.clk(clk), .en(adv), .a(k3), .b(r6), .p(k3r6));
  rld_mulq u_mul_k6r6 (.clk(clk), .en(adv), .a(k6), .b(r6), .p(k6r6));

  // Numerator and denominator accumulate as their terms arrive.
  always_ff @(posedge clk) begin
    if (adv) begin
      nd1_r.x <= rld_pkg::sadd(rld_pkg::ONE_Q28, k1r2);
      nd1_r.y <= rld_pkg::sadd(rld_pkg::ONE_Q28, k4r2);
      nd1_d_r[0] <= nd1_r;
      for (int i = 1; i < D_N1; i++) nd1_d_r[i] <= nd1_d_r[i-1];
      nd2_r.x <= rld_pkg::sadd(nd1_d_r[D_N1-1].x, k2r4);
      nd2_r.y <= rld_pkg::sadd(nd1_d_r[D_N1-1].y, k5r4);
      nd2_d_r[0] <= nd2_r;
      for (int i = 1; i < D_N2; i++) nd2_d_r[i] <= nd2_d_r[i-1];
      num_r <= rld_pkg::sadd(nd2_d_r[D_N2-1].x, k3r6);
      den_r <= rld_pkg::sadd(nd2_d_r[D_N2-1].y, k6r6);
      bad_d_r[0] <= den_r <= 0;
      for (int i = 1; i < D_BAD; i++) bad_d_r[i] <= bad_d_r[i-1];
    end
  end

  rld_div u_div (.clk(clk), .en(adv), .num(num_r), .den(den_r), .quo(ratio));

  // Radial term and the final distorted coordinate in normalized units.
  rld_mulq u_mul_rx (.clk(clk), .en(adv), .a(xn_d_r[D_XN-1].x), .b(ratio), .p(rx));
  rld_mulq u_mul_ry (.clk(clk), .en(adv), .a(xn_d_r[D_XN-1].y), .b(ratio), .p(ry));

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r.x <= rld_pkg::sadd(rx, tg_d_r[D_TG-1].x);
      dx_r.y <= rld_pkg::sadd(ry, tg_d_r[D_TG-1].y);
    end
  end

  // Back to pixels: scale by the half-size, drop 20 bits, recenter and clamp.
  rld_mulq u_mul_vx (.clk(clk), .en(adv), .a(dx_r.x), .b(SCALE[0]), .p(vx));
  rld_mulq u_mul_vy (.clk(clk), .en(adv), .a(dx_r.y), .b(SCALE[1]), .p(vy));

  always_comb begin
    vmag_nxt[0] = (vx < 0) ? 64'(-vx) : 64'(vx);
    vmag_nxt[1] = (vy < 0) ? 64'(-vy) : 64'(vy);
    q8_nxt[0] = (vx < 0) ? -Q8'(vmag_nxt[0][62:rld_pkg::PIX_SHIFT])
                         : Q8'(vmag_nxt[0][62:rld_pkg::PIX_SHIFT]);
    q8_nxt[1] = (vy < 0) ? -Q8'(vmag_nxt[1][62:rld_pkg::PIX_SHIFT])
                         : Q8'(vmag_nxt[1][62:rld_pkg::PIX_SHIFT]);
    for (int a = 0; a < 2; a++) begin
      pix_nxt[a] = q8_r[a] + OFF8[a];
      if (pix_nxt[a] > Q8'(524287)) begin
        clamp_nxt[a] = PW'(524287);
      end else if (pix_nxt[a] < -Q8'(524288)) begin
        clamp_nxt[a] = PW'(-524288);
      end else begin
        clamp_nxt[a] = pix_nxt[a][PW-1:0];
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (adv) begin
      q8_r[0]  <= q8_nxt[0];
      q8_r[1]  <= q8_nxt[1];
      bad_r    <= bad_d_r[D_BAD-1];
      dist_x_r <= bad_d_r[D_BAD-1] ? in_d_r[D_IN-1].pos_x : clamp_nxt[0];
      dist_y_r <= bad_d_r[D_BAD-1] ? in_d_r[D_IN-1].pos_y : clamp_nxt[1];
      tex_u_r  <= in_d_r[D_IN-1].tex_u;
      tex_v_r  <= in_d_r[D_IN-1].tex_v;
    end
  end

  assign out_ch.valid           = vld_r[T_OUT];
  assign out_ch.dist_x          = dist_x_r;
  assign out_ch.dist_y          = dist_y_r;
  assign out_ch.tex_u_out       = tex_u_r;
  assign out_ch.tex_v_out       = tex_v_r;
  assign out_ch.bad_denominator = bad_r;

endmodule

`default_nettype wire
